>>> rtl/rcph_pkg.sv
// Package for the chunk header parser: field widths, decode phases and
// the decoded header record. No dependencies.
package rcph_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned FmtW    = 2;
    localparam int unsigned CsidW   = 17;
    localparam int unsigned TsW     = 32;
    localparam int unsigned LenW    = 24;
    localparam int unsigned TypeW   = 8;
    localparam int unsigned MsidW   = 32;
    localparam int unsigned HlenW   = 5;
    localparam int unsigned OutW    = FmtW + CsidW + TsW + LenW + TypeW + MsidW + HlenW;

    // Basic header id escapes and timestamp escape
    localparam logic [5:0]     CsidExt1   = 6'h00;
    localparam logic [5:0]     CsidExt2   = 6'h01;
    localparam logic [CsidW-1:0] CsidBase = 17'd64;
    localparam logic [FmtW-1:0] Fmt1      = 2'd1;
    localparam logic [FmtW-1:0] Fmt2      = 2'd2;
    localparam logic [FmtW-1:0] Fmt3      = 2'd3;
    localparam logic [TsW-1:0] TsEscape   = 32'h00ff_ffff;

    // Decode phase, one-hot
    typedef enum logic [18:0] {
        PH_IDLE = 19'h00001,
        PH_ID1  = 19'h00002,
        PH_ID2A = 19'h00004,
        PH_ID2B = 19'h00008,
        PH_TS0  = 19'h00010,
        PH_TS1  = 19'h00020,
        PH_TS2  = 19'h00040,
        PH_LEN0 = 19'h00080,
        PH_LEN1 = 19'h00100,
        PH_LEN2 = 19'h00200,
        PH_TYPE = 19'h00400,
        PH_MS0  = 19'h00800,
        PH_MS1  = 19'h01000,
        PH_MS2  = 19'h02000,
        PH_MS3  = 19'h04000,
        PH_EXT0 = 19'h08000,
        PH_EXT1 = 19'h10000,
        PH_EXT2 = 19'h20000,
        PH_EXT3 = 19'h40000
    } t_phase;

    // One decoded chunk header
    typedef struct packed {
        logic [FmtW-1:0]  chunk_format;
        logic [CsidW-1:0] chunk_stream_id;
        logic [TsW-1:0]   timestamp;
        logic [LenW-1:0]  message_length;
        logic [TypeW-1:0] message_type;
        logic [MsidW-1:0] message_stream_id;
        logic [HlenW-1:0] header_length;
    } t_hdr;

endpackage

>>> rtl/rcph_core.sv
// Chunk header decode: phase machine and field accumulators, one byte per
// enabled cycle, flags a complete header. Depends on rcph_pkg.
module rcph_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [rcph_pkg::ByteW-1:0]  i_byte,
    input  logic                        i_start,
    output logic                        o_emit,
    output rcph_pkg::t_hdr              o_hdr
);

    rcph_pkg::t_phase r_phase, n_phase;
    logic [rcph_pkg::FmtW-1:0]  r_fmt,  n_fmt;
    logic [rcph_pkg::CsidW-1:0] r_csid, n_csid;
    logic [rcph_pkg::TsW-1:0]   r_ts,   n_ts;
    logic [rcph_pkg::LenW-1:0]  r_len,  n_len;
    logic [rcph_pkg::TypeW-1:0] r_type, n_type;
    logic [rcph_pkg::MsidW-1:0] r_msid, n_msid;
    logic [rcph_pkg::HlenW-1:0] r_cnt,  n_cnt;
    logic                       do_basic, do_body, emit;
    logic [5:0]                 low;

    // Next-state decode
    always_comb begin
        n_phase  = r_phase;
        n_fmt    = r_fmt;
        n_csid   = r_csid;
        n_ts     = r_ts;
        n_len    = r_len;
        n_type   = r_type;
        n_msid   = r_msid;
        n_cnt    = r_cnt;
        do_basic = 1'b0;
        do_body  = 1'b0;
        emit     = 1'b0;
        low      = i_byte[5:0];

        if (i_start) begin
            n_fmt  = i_byte[7:6];
            n_csid = {11'd0, low};
            n_ts   = '0;
            n_len  = '0;
            n_type = '0;
            n_msid = '0;
            n_cnt  = 5'd1;
            if (low == rcph_pkg::CsidExt1) begin
                n_phase = rcph_pkg::PH_ID1;
            end else if (low == rcph_pkg::CsidExt2) begin
                n_phase = rcph_pkg::PH_ID2A;
            end else begin
                do_basic = 1'b1;
            end
        end else if (r_phase != rcph_pkg::PH_IDLE) begin
            n_cnt = r_cnt + 5'd1;
            unique case (r_phase)
                rcph_pkg::PH_ID1: begin
                    n_csid   = rcph_pkg::CsidBase + {9'd0, i_byte};
                    do_basic = 1'b1;
                end
                rcph_pkg::PH_ID2A: begin
                    n_csid  = rcph_pkg::CsidBase + {9'd0, i_byte};
                    n_phase = rcph_pkg::PH_ID2B;
                end
                rcph_pkg::PH_ID2B: begin
                    n_csid   = r_csid + {1'b0, i_byte, 8'd0};
                    do_basic = 1'b1;
                end
                rcph_pkg::PH_TS0: begin
                    n_ts    = {8'd0, r_ts[15:0], i_byte};
                    n_phase = rcph_pkg::PH_TS1;
                end
                rcph_pkg::PH_TS1: begin
                    n_ts    = {8'd0, r_ts[15:0], i_byte};
                    n_phase = rcph_pkg::PH_TS2;
                end
                rcph_pkg::PH_TS2: begin
                    n_ts = {8'd0, r_ts[15:0], i_byte};
                    if (r_fmt == rcph_pkg::Fmt2) begin
                        do_body = 1'b1;
                    end else begin
                        n_phase = rcph_pkg::PH_LEN0;
                    end
                end
                rcph_pkg::PH_LEN0: begin
                    n_len   = {r_len[15:0], i_byte};
                    n_phase = rcph_pkg::PH_LEN1;
                end
                rcph_pkg::PH_LEN1: begin
                    n_len   = {r_len[15:0], i_byte};
                    n_phase = rcph_pkg::PH_LEN2;
                end
                rcph_pkg::PH_LEN2: begin
                    n_len   = {r_len[15:0], i_byte};
                    n_phase = rcph_pkg::PH_TYPE;
                end
                rcph_pkg::PH_TYPE: begin
                    n_type = i_byte;
                    if (r_fmt == rcph_pkg::Fmt1) begin
                        do_body = 1'b1;
                    end else begin
                        n_phase = rcph_pkg::PH_MS0;
                    end
                end
                // Message stream id arrives little-endian
                rcph_pkg::PH_MS0: begin
                    n_msid[7:0] = i_byte;
                    n_phase     = rcph_pkg::PH_MS1;
                end
                rcph_pkg::PH_MS1: begin
                    n_msid[15:8] = i_byte;
                    n_phase      = rcph_pkg::PH_MS2;
                end
                rcph_pkg::PH_MS2: begin
                    n_msid[23:16] = i_byte;
                    n_phase       = rcph_pkg::PH_MS3;
                end
                rcph_pkg::PH_MS3: begin
                    n_msid[31:24] = i_byte;
                    do_body       = 1'b1;
                end
                // Extended timestamp replaces the escaped one
                rcph_pkg::PH_EXT0: begin
                    n_ts    = {24'd0, i_byte};
                    n_phase = rcph_pkg::PH_EXT1;
                end
                rcph_pkg::PH_EXT1: begin
                    n_ts    = {r_ts[23:0], i_byte};
                    n_phase = rcph_pkg::PH_EXT2;
                end
                rcph_pkg::PH_EXT2: begin
                    n_ts    = {r_ts[23:0], i_byte};
                    n_phase = rcph_pkg::PH_EXT3;
                end
                rcph_pkg::PH_EXT3: begin
                    n_ts = {r_ts[23:0], i_byte};
                    emit = 1'b1;
                end
                default: begin
                    n_phase = rcph_pkg::PH_IDLE;
                end
            endcase
        end

        // End of basic header: body follows unless format 3
        if (do_basic) begin
            if (n_fmt == rcph_pkg::Fmt3) begin
                emit = 1'b1;
            end else begin
                n_phase = rcph_pkg::PH_TS0;
            end
        end
        // End of body: escaped timestamp pulls in four more bytes
        if (do_body) begin
            if (n_ts == rcph_pkg::TsEscape) begin
                n_phase = rcph_pkg::PH_EXT0;
            end else begin
                emit = 1'b1;
            end
        end
        if (emit) begin
            n_phase = rcph_pkg::PH_IDLE;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rcph_pkg::PH_IDLE;
            r_fmt   <= '0;
            r_csid  <= '0;
            r_ts    <= '0;
            r_len   <= '0;
            r_type  <= '0;
            r_msid  <= '0;
            r_cnt   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_fmt   <= n_fmt;
            r_csid  <= n_csid;
            r_ts    <= n_ts;
            r_len   <= n_len;
            r_type  <= n_type;
            r_msid  <= n_msid;
            r_cnt   <= n_cnt;
        end
    end

    assign o_emit = i_en & emit;
    assign o_hdr  = '{chunk_format:      n_fmt,
                      chunk_stream_id:   n_csid,
                      timestamp:         n_ts,
                      message_length:    n_len,
                      message_type:      n_type,
                      message_stream_id: n_msid,
                      header_length:     n_cnt};

endmodule

>>> rtl/rtmp_chunk_header_parser.sv
// RTMP chunk header parser, top level. Input register, decode core, result
// register. Depends on rcph_pkg and rcph_core.
// A header's result is registered in the result register once the core takes its last byte beat.
// Throughput: one byte per cycle while the result slot is free or draining, set
// by the phase decode; input is taken while a result waits if the slot frees.
// Reset (synchronous, active low) empties both registers and returns the
// decoder to waiting for a header start with all fields zero.
module rtmp_chunk_header_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // data_byte
    input  logic                          i_s_axis_tuser,  // header_start
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // chunk_format, chunk_stream_id, timestamp, message_length,
    // message_type, message_stream_id, header_length
    output logic [rcph_pkg::OutW-1:0]     o_m_axis_tdata
);

    logic                       r_in_valid;
    logic [rcph_pkg::ByteW-1:0] r_in_byte;
    logic                       r_in_start;
    logic                       r_out_valid;
    rcph_pkg::t_hdr             r_out_hdr;
    logic                       advance;
    logic                       emit;
    rcph_pkg::t_hdr             hdr;

    // Core consumes a held beat when the result slot is free or draining
    assign advance         = r_in_valid & (~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_start <= i_s_axis_tuser;
        end
    end

    rcph_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_byte  (r_in_byte),
        .i_start (r_in_start),
        .o_emit  (emit),
        .o_hdr   (hdr)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_hdr <= hdr;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_hdr.header_length,
                              r_out_hdr.message_stream_id,
                              r_out_hdr.message_type,
                              r_out_hdr.message_length,
                              r_out_hdr.timestamp,
                              r_out_hdr.chunk_stream_id,
                              r_out_hdr.chunk_format};

endmodule
